/* hw/rtl/unt_pkg.sv */
// Shared types, codes and fixed port widths of the UID node table.
`default_nettype none

package unt_pkg;

    // Fixed field widths of the command and result ports
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 64;
    localparam int EIDX_W   = 4;
    localparam int NOW_W    = 32;
    localparam int STATUS_W = 3;
    localparam int NODE_W   = 4;

    // Defaults for the top-level parameters
    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_UID_BITS    = 64;
    localparam int DEF_STAMP_BITS  = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] STS_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] STS_FILLED   = 3'd2;
    localparam logic [STATUS_W-1:0] STS_EVICTED  = 3'd3;
    localparam logic [STATUS_W-1:0] STS_WAS_FREE = 3'd4;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DRAIN,
        FSM_COMMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;     // latch the item, rewind the scan, drop old search results
        logic scan_rd;  // read the entry at the scan pointer and advance it
        logic commit;   // apply the command and issue the result
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last; // scan pointer sits on the last entry
    } ctrl_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/unt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module unt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/unt_ctrl.sv */
// Sequencing state machine of the UID node table.
`default_nettype none

module unt_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [unt_pkg::CMD_W-1:0] cmd,
    input  wire unt_pkg::ctrl_sts_t        sts,
    output unt_pkg::ctrl_cmd_t             ctl,
    output logic                           busy
);

    unt_pkg::state_t state_reg;
    unt_pkg::state_t state_next;
    logic            accept;
    logic            is_search;

    assign accept    = start && (state_reg == unt_pkg::FSM_IDLE);
    assign is_search = (cmd == unt_pkg::CMD_GET) || (cmd == unt_pkg::CMD_LOOKUP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= unt_pkg::FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            unt_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = is_search ? unt_pkg::FSM_SCAN : unt_pkg::FSM_COMMIT;
                end
            end
            unt_pkg::FSM_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = unt_pkg::FSM_DRAIN;
                end
            end
            unt_pkg::FSM_DRAIN:
            begin
                state_next = unt_pkg::FSM_COMMIT;
            end
            unt_pkg::FSM_COMMIT:
            begin
                state_next = unt_pkg::FSM_IDLE;
            end
            default:
            begin
                state_next = unt_pkg::FSM_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl.load    = 1'b0;
        ctl.scan_rd = 1'b0;
        ctl.commit  = 1'b0;
        busy        = 1'b1;
        case (state_reg)
            unt_pkg::FSM_IDLE:
            begin
                busy     = 1'b0;
                ctl.load = start;
            end
            unt_pkg::FSM_SCAN:
            begin
                ctl.scan_rd = 1'b1;
            end
            unt_pkg::FSM_DRAIN:
            begin
                ctl.scan_rd = 1'b0;
            end
            unt_pkg::FSM_COMMIT:
            begin
                ctl.commit = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    a_search_scans: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_search |=> state_reg == unt_pkg::FSM_SCAN)
        else $error("search item did not enter the scan");

    a_direct_commits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_search |=> ctl.commit)
        else $error("free or clear item did not commit next cycle");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == unt_pkg::FSM_SCAN && sts.scan_last |=> state_reg == unt_pkg::FSM_DRAIN)
        else $error("scan ran past the last entry");

endmodule

`default_nettype wire

/* hw/rtl/unt_dpath.sv */
// Datapath of the UID node table: entry store, valid bits, scan trackers, result.
`default_nettype none

module unt_dpath #(
    parameter int TABLE_DEPTH = unt_pkg::DEF_TABLE_DEPTH,
    parameter int UID_BITS    = unt_pkg::DEF_UID_BITS,
    parameter int STAMP_BITS  = unt_pkg::DEF_STAMP_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire unt_pkg::ctrl_cmd_t           ctl,
    output unt_pkg::ctrl_sts_t                sts,
    input  wire logic [unt_pkg::CMD_W-1:0]    cmd,
    input  wire logic [unt_pkg::KEY_W-1:0]    key_uid,
    input  wire logic [unt_pkg::EIDX_W-1:0]   entry_index,
    input  wire logic [unt_pkg::NOW_W-1:0]    now_ms,
    output logic                              done,
    output logic      [unt_pkg::STATUS_W-1:0] status,
    output logic      [unt_pkg::NODE_W-1:0]   node_index
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int NW     = (IDX_W > unt_pkg::NODE_W) ? IDX_W : unt_pkg::NODE_W;
    localparam int DATA_W = UID_BITS + STAMP_BITS;

    // Latched item
    logic [unt_pkg::CMD_W-1:0]  cmd_reg;
    logic [UID_BITS-1:0]        key_reg;
    logic [STAMP_BITS-1:0]      now_reg;
    logic [unt_pkg::EIDX_W-1:0] eidx_reg;

    // Scan pointer and read pipeline
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [DATA_W-1:0] rd_data;
    logic [UID_BITS-1:0]   rd_uid;
    logic [STAMP_BITS-1:0] rd_stamp;
    logic                  rd_valid;

    // Trackers
    logic hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic le_found_reg, le_found_next;
    logic [IDX_W-1:0] le_idx_reg, le_idx_next;
    logic [STAMP_BITS-1:0] le_stamp_reg, le_stamp_next;
    logic any_found_reg, any_found_next;
    logic [IDX_W-1:0] any_idx_reg, any_idx_next;
    logic [STAMP_BITS-1:0] any_stamp_reg, any_stamp_next;

    // Table state and result
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic                   done_reg, done_next;
    logic [unt_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [unt_pkg::NODE_W-1:0]   node_reg, node_next;

    // Commit decode
    logic             ins_wr;
    logic [IDX_W-1:0] ins_slot;
    logic [NW-1:0]    slot_ext;
    logic [NW-1:0]    eidx_ext;
    logic [IDX_W-1:0] free_slot;
    logic             free_in_range;

    assign rd_uid   = rd_data[STAMP_BITS +: UID_BITS];
    assign rd_stamp = rd_data[STAMP_BITS-1:0];
    assign rd_valid = valid_reg[rd_idx_reg];

    assign sts.scan_last = (cnt_reg == IDX_W'(TABLE_DEPTH - 1));

    assign eidx_ext      = NW'(eidx_reg);
    assign free_slot     = IDX_W'(eidx_ext);
    assign free_in_range = (32'(eidx_reg) < TABLE_DEPTH);

    always_comb
    begin
        if (free_found_reg)
        begin
            ins_slot = free_idx_reg;
        end
        else if (le_found_reg)
        begin
            ins_slot = le_idx_reg;
        end
        else
        begin
            ins_slot = any_idx_reg;
        end
    end

    assign ins_wr   = ctl.commit && (cmd_reg == unt_pkg::CMD_GET) && !hit_found_reg;
    assign slot_ext = NW'(hit_found_reg ? hit_idx_reg : ins_slot);

    unt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ins_wr),
        .wr_addr (ins_slot),
        .wr_data ({key_reg, now_reg}),
        .rd_en   (ctl.scan_rd),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    // Scan pointer
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.load)
        begin
            cnt_next = '0;
        end
        else if (ctl.scan_rd)
        begin
            cnt_next = cnt_reg + IDX_W'(1);
        end
    end

    // Trackers: first hit, first free, oldest at or below now, oldest overall
    always_comb
    begin
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        le_found_next   = le_found_reg;
        le_idx_next     = le_idx_reg;
        le_stamp_next   = le_stamp_reg;
        any_found_next  = any_found_reg;
        any_idx_next    = any_idx_reg;
        any_stamp_next  = any_stamp_reg;
        if (ctl.load)
        begin
            hit_found_next  = 1'b0;
            free_found_next = 1'b0;
            le_found_next   = 1'b0;
            any_found_next  = 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (rd_valid && !hit_found_reg && (rd_uid == key_reg))
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = rd_idx_reg;
            end
            if (!rd_valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = rd_idx_reg;
            end
            if (rd_valid && (rd_stamp <= now_reg) && (!le_found_reg || rd_stamp <= le_stamp_reg))
            begin
                le_found_next = 1'b1;
                le_idx_next   = rd_idx_reg;
                le_stamp_next = rd_stamp;
            end
            if (rd_valid && (!any_found_reg || rd_stamp <= any_stamp_reg))
            begin
                any_found_next = 1'b1;
                any_idx_next   = rd_idx_reg;
                any_stamp_next = rd_stamp;
            end
        end
    end

    // Commit: table update and result
    always_comb
    begin
        valid_next  = valid_reg;
        done_next   = ctl.commit;
        status_next = status_reg;
        node_next   = node_reg;
        if (ctl.commit)
        begin
            status_next = unt_pkg::STS_HIT;
            node_next   = '0;
            case (cmd_reg)
                unt_pkg::CMD_GET:
                begin
                    node_next = slot_ext[unt_pkg::NODE_W-1:0];
                    if (!hit_found_reg)
                    begin
                        valid_next[ins_slot] = 1'b1;
                        status_next = free_found_reg ? unt_pkg::STS_FILLED
                                                     : unt_pkg::STS_EVICTED;
                    end
                end
                unt_pkg::CMD_LOOKUP:
                begin
                    if (hit_found_reg)
                    begin
                        node_next = slot_ext[unt_pkg::NODE_W-1:0];
                    end
                    else
                    begin
                        status_next = unt_pkg::STS_MISS;
                    end
                end
                unt_pkg::CMD_FREE:
                begin
                    node_next = eidx_reg;
                    if (free_in_range && valid_reg[free_slot])
                    begin
                        valid_next[free_slot] = 1'b0;
                    end
                    else
                    begin
                        status_next = unt_pkg::STS_WAS_FREE;
                    end
                end
                unt_pkg::CMD_CLEAR:
                begin
                    valid_next = '0;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            done_reg       <= 1'b0;
            rd_vld_reg     <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            le_found_reg   <= 1'b0;
            any_found_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            done_reg       <= done_next;
            rd_vld_reg     <= ctl.scan_rd;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            le_found_reg   <= le_found_next;
            any_found_reg  <= any_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd;
            key_reg  <= UID_BITS'(key_uid);
            now_reg  <= STAMP_BITS'(now_ms);
            eidx_reg <= entry_index;
        end
        cnt_reg       <= cnt_next;
        rd_idx_reg    <= cnt_reg;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        le_idx_reg    <= le_idx_next;
        le_stamp_reg  <= le_stamp_next;
        any_idx_reg   <= any_idx_next;
        any_stamp_reg <= any_stamp_next;
        status_reg    <= status_next;
        node_reg      <= node_next;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign node_index = node_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == unt_pkg::STS_EVICTED |-> &valid_reg)
        else $error("eviction reported while the table had a free slot");

    a_insert_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ins_wr |=> valid_reg[$past(ins_slot)])
        else $error("inserted entry not marked valid");

endmodule

`default_nettype wire

/* hw/rtl/uid_node_table_with_oldest_eviction.sv */
// Top level of the UID node table with oldest-stamp replacement.
//
//  channel   | handshake            | fields
//  ----------+----------------------+------------------------------------------
//  command   | start / busy         | cmd, key_uid, entry_index, now_ms
//  result    | done (1-cycle pulse) | status, node_index
//
// An item is taken at a rising edge with start high and busy low.
// get and lookup scan the entry store one entry per cycle through its
// single read port, then drain the read pipe and commit; the next item can be
// taken at the edge that ends the result strobe.
// free and clear skip the scan and commit directly, touching only the valid bits.
// Reset empties the table at once: the valid bits clear in flip-flops, the
// stored IDs and stamps are left as they are and never used while invalid.
// The receiver cannot stall; each result stands for exactly one cycle.
`default_nettype none

module uid_node_table_with_oldest_eviction #(
    parameter int TABLE_DEPTH = unt_pkg::DEF_TABLE_DEPTH,
    parameter int UID_BITS    = unt_pkg::DEF_UID_BITS,
    parameter int STAMP_BITS  = unt_pkg::DEF_STAMP_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [unt_pkg::CMD_W-1:0]    cmd,
    input  wire logic [unt_pkg::KEY_W-1:0]    key_uid,
    input  wire logic [unt_pkg::EIDX_W-1:0]   entry_index,
    input  wire logic [unt_pkg::NOW_W-1:0]    now_ms,
    output logic                              done,
    output logic      [unt_pkg::STATUS_W-1:0] status,
    output logic      [unt_pkg::NODE_W-1:0]   node_index
);

    unt_pkg::ctrl_cmd_t ctl;
    unt_pkg::ctrl_sts_t sts;

    // Sequence each item: accept, scan and drain the read pipe for get and lookup, commit
    unt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    // Hold the entries, track match, free slot and eviction victim, drive the result
    unt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .UID_BITS    (UID_BITS),
        .STAMP_BITS  (STAMP_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .cmd         (cmd),
        .key_uid     (key_uid),
        .entry_index (entry_index),
        .now_ms      (now_ms),
        .done        (done),
        .status      (status),
        .node_index  (node_index)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_uid_node_table_with_oldest_eviction.sv */
// Self-checking testbench of the UID node table: directed and random items against a mirror.
`timescale 1ns / 100ps

module tb_uid_node_table_with_oldest_eviction;

    localparam int DEPTH      = unt_pkg::DEF_TABLE_DEPTH;
    localparam int CMD_W      = unt_pkg::CMD_W;
    localparam int KEY_W      = unt_pkg::KEY_W;
    localparam int EIDX_W     = unt_pkg::EIDX_W;
    localparam int NOW_W      = unt_pkg::NOW_W;
    localparam int STATUS_W   = unt_pkg::STATUS_W;
    localparam int NODE_W     = unt_pkg::NODE_W;
    localparam int POOL_SIZE  = 24;       // more IDs than entries, so gets keep evicting
    localparam int PHASE_REQS = 220;
    localparam int CYCLE_CAP  = 200000;   // watchdog bound on the run
    localparam int TAIL_WAIT  = 40;       // beyond the scan of a get or lookup

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key;
        logic [EIDX_W-1:0] idx;
        logic [NOW_W-1:0]  now;
    } node_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NODE_W-1:0]   node;
    } node_rsp_t;

    // Block ports; every input starts at a known value
    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic [CMD_W-1:0]    cmd         = unt_pkg::CMD_GET;
    logic [KEY_W-1:0]    key_uid     = '0;
    logic [EIDX_W-1:0]   entry_index = '0;
    logic [NOW_W-1:0]    now_ms      = '0;
    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   node_index;

    // Items waiting for the driver, and results owed by the block
    node_req_t queued_reqs[$];
    node_rsp_t owed_results[$];

    // Mirror of the table contents
    logic             mirror_valid [DEPTH];
    logic [KEY_W-1:0] mirror_uid   [DEPTH];
    logic [NOW_W-1:0] mirror_stamp [DEPTH];

    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    logic [NOW_W-1:0] clock_ms;
    logic             req_taken  = 1'b0;
    int               idle_pct   = 0;
    int               mismatches = 0;
    int               cycle_count = 0;
    node_rsp_t        want_rsp;
    node_rsp_t        pred_rsp;
    node_req_t        next_req;

    uid_node_table_with_oldest_eviction u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .key_uid     (key_uid),
        .entry_index (entry_index),
        .now_ms      (now_ms),
        .done        (done),
        .status      (status),
        .node_index  (node_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the result of one accepted item and advance the mirror.
    task automatic predict_node_result(input node_req_t req, output node_rsp_t rsp);
        int               hit;
        int               slot;
        logic [NOW_W-1:0] best;
        hit        = -1;
        slot       = -1;
        rsp.status = unt_pkg::STS_HIT;
        rsp.node   = '0;
        case (req.cmd)
            unt_pkg::CMD_GET, unt_pkg::CMD_LOOKUP:
            begin
                // The lowest valid entry holding the key is the match
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (hit < 0 && mirror_valid[i] && mirror_uid[i] == req.key)
                        hit = i;
                end
                if (hit >= 0)
                    rsp.node = NODE_W'(hit);
                else if (req.cmd == unt_pkg::CMD_LOOKUP)
                    rsp.status = unt_pkg::STS_MISS;
                else
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (slot < 0 && !mirror_valid[i])
                            slot = i;
                    end
                    if (slot >= 0)
                        rsp.status = unt_pkg::STS_FILLED;
                    else
                    begin
                        // Oldest stamp not above now; the highest index wins ties
                        best = req.now;
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (mirror_stamp[i] <= best)
                            begin
                                best = mirror_stamp[i];
                                slot = i;
                            end
                        end
                        // Every stamp is in the future: take the smallest of all
                        if (slot < 0)
                        begin
                            best = '1;
                            for (int i = 0; i < DEPTH; i++)
                            begin
                                if (mirror_stamp[i] <= best)
                                begin
                                    best = mirror_stamp[i];
                                    slot = i;
                                end
                            end
                        end
                        rsp.status = unt_pkg::STS_EVICTED;
                    end
                    mirror_valid[slot] = 1'b1;
                    mirror_uid[slot]   = req.key;
                    mirror_stamp[slot] = req.now;
                    rsp.node           = NODE_W'(slot);
                end
            end
            unt_pkg::CMD_FREE:
            begin
                rsp.node = req.idx;
                if (mirror_valid[req.idx])
                    mirror_valid[req.idx] = 1'b0;
                else
                    rsp.status = unt_pkg::STS_WAS_FREE;
            end
            default:
            begin
                for (int i = 0; i < DEPTH; i++)
                    mirror_valid[i] = 1'b0;
            end
        endcase
    endtask

    task automatic push_req(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                            input logic [EIDX_W-1:0] x, input logic [NOW_W-1:0] t);
        node_req_t req;
        req.cmd = c;
        req.key = k;
        req.idx = x;
        req.now = t;
        queued_reqs.push_back(req);
    endtask

    // Hold until every queued item is taken and every owed result has come.
    // Sample at the rising edge, where the queue and start are stable.
    task automatic wait_table_drained();
        @(posedge clk);
        while (queued_reqs.size() != 0 || start || owed_results.size() != 0)
            @(posedge clk);
    endtask

    // Driver: change inputs at the falling edge. Hold an offered item until the
    // edge that takes it, then either offer the next one or idle at random.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || req_taken)
        begin
            if (queued_reqs.size() == 0 || $urandom_range(0, 99) < idle_pct)
                start <= 1'b0;
            else
            begin
                next_req    = queued_reqs.pop_front();
                start       <= 1'b1;
                cmd         <= next_req.cmd;
                key_uid     <= next_req.key;
                entry_index <= next_req.idx;
                now_ms      <= next_req.now;
            end
        end
    end

    // Monitor: sample at the rising edge. Retire a result first, since the next
    // item may be taken on the same edge that strobes the previous result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result with none owed: status %0d node %0d",
                             $time, status, node_index);
                    mismatches++;
                end
                else
                begin
                    want_rsp = owed_results.pop_front();
                    if (status !== want_rsp.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want_rsp.status, status);
                        mismatches++;
                    end
                    if (node_index !== want_rsp.node)
                    begin
                        $display("%0t: node_index expected %0d, got %0d",
                                 $time, want_rsp.node, node_index);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                predict_node_result({cmd, key_uid, entry_index, now_ms}, pred_rsp);
                owed_results.push_back(pred_rsp);
            end
        end
        req_taken <= rst_n && start && !busy;
    end

    // Watchdog: end the run if the block stops answering
    initial
    begin
        while (cycle_count < CYCLE_CAP)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("uid_node_table_with_oldest_eviction regression: fail");
        $finish;
    end

    initial
    begin
        int               r;
        logic [CMD_W-1:0] rc;
        logic [KEY_W-1:0] rk;
        logic [NOW_W-1:0] rt;

        for (int i = 0; i < DEPTH; i++)
        begin
            mirror_valid[i] = 1'b0;
            mirror_uid[i]   = '0;
            mirror_stamp[i] = '0;
        end
        // Distinct IDs: the low word tells them apart, one of them is all ones
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, 32'(i)};
        key_pool[15] = '1;
        clock_ms = $urandom;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, hit, free and double free, clear
        push_req(unt_pkg::CMD_LOOKUP, '1, '0, '0);
        push_req(unt_pkg::CMD_FREE, '0, 4'hF, '0);
        push_req(unt_pkg::CMD_GET, '0, '0, '0);
        push_req(unt_pkg::CMD_GET, '0, 4'hF, '1);
        push_req(unt_pkg::CMD_FREE, '1, 4'h0, '1);
        push_req(unt_pkg::CMD_FREE, '0, 4'h0, '0);
        push_req(unt_pkg::CMD_CLEAR, '1, 4'hF, '1);
        // Fill the table: entry 0 newest possible, entries 5 and 11 tie oldest
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
                rt = '1;
            else if (i == 5 || i == 11)
                rt = 32'h10;
            else
                rt = 32'h100 + 32'(i);
            push_req(unt_pkg::CMD_GET, key_pool[i], EIDX_W'(i), rt);
        end
        // Tie on the oldest stamp: the higher index goes
        push_req(unt_pkg::CMD_GET, key_pool[16], '0, 32'h20);
        // No stamp at or below now: evict the smallest stamp anyway
        push_req(unt_pkg::CMD_GET, key_pool[17], '0, 32'h5);
        push_req(unt_pkg::CMD_LOOKUP, key_pool[3], '0, '0);
        push_req(unt_pkg::CMD_LOOKUP, key_pool[11], '0, '0);
        wait_table_drained();

        // Random phases: no idling, sender idle half the time, light idling, none
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = (p == 1) ? 50 : (p == 2) ? 8 : 0;
            for (int n = 0; n < PHASE_REQS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 58)
                    rc = unt_pkg::CMD_GET;
                else if (r < 88)
                    rc = unt_pkg::CMD_LOOKUP;
                else if (r < 99)
                    rc = unt_pkg::CMD_FREE;
                else
                    rc = unt_pkg::CMD_CLEAR;
                // Mostly known IDs so gets hit and evict; the rest is noise
                if ($urandom_range(0, 99) < 85)
                    rk = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    rk = {$urandom, $urandom};
                // Advance time slowly, with repeats for ties and rare jumps anywhere
                clock_ms = clock_ms + NOW_W'($urandom_range(0, 4));
                if ($urandom_range(0, 9) == 0)
                    rt = $urandom;
                else
                    rt = clock_ms;
                push_req(rc, rk, EIDX_W'($urandom_range(0, DEPTH - 1)), rt);
            end
            wait_table_drained();
        end

        // Catch any stray result after the last one owed
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("uid_node_table_with_oldest_eviction regression: pass");
        else
            $display("uid_node_table_with_oldest_eviction regression: fail");
        $finish;
    end

endmodule
